### src/ddwo_pkg.sv
`timescale 1ns / 1ps
package ddwo_pkg;

	localparam int CordicSteps = 16;
	localparam int StepW = 6;

	localparam logic signed [31:0] QPi = 32'sd205887;
	localparam logic signed [31:0] QTwoPi = 32'sd411775;
	localparam logic signed [31:0] QHalfPi = 32'sd102944;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic [19:0] UsPerS = 20'd1000000;

	localparam logic [15:0] RadiusReset = 16'd2163;
	localparam logic [17:0] SepReset = 18'd11141;

	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_SEP = 1'b1
	} reg_idx_t;

	// request to the shared divider
	typedef struct packed {
		logic start;
		logic signed [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [33:0] cos_q;
		logic signed [33:0] sin_q;
	} cordic_rsp_t;

	function automatic logic signed [33:0] atan_q30(input logic [StepW-1:0] i);
		logic signed [33:0] v;
		begin
			case (i)
				6'd0: v = 34'sd843314857;
				6'd1: v = 34'sd497837829;
				6'd2: v = 34'sd263043837;
				6'd3: v = 34'sd133525159;
				6'd4: v = 34'sd67021687;
				6'd5: v = 34'sd33543516;
				6'd6: v = 34'sd16775851;
				6'd7: v = 34'sd8388437;
				6'd8: v = 34'sd4194283;
				6'd9: v = 34'sd2097149;
				6'd10: v = 34'sd1048575;
				6'd31: v = 34'sd0;
				default: v = (i < 6'd31) ? (34'sd1 <<< (6'd30 - i)) : 34'sd0;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		begin
			if (v > 66'sd2147483647) r = 32'sh7fffffff;
			else if (v < -66'sd2147483648) r = 32'sh80000000;
			else r = v[31:0];
			return r;
		end
	endfunction

endpackage

### src/ddwo_div.sv
`timescale 1ns / 1ps
module ddwo_div (
	input logic clk,
	input logic arst_n,
	input ddwo_pkg::div_req_t req,
	output ddwo_pkg::div_rsp_t rsp
);
	import ddwo_pkg::*;

	// restoring division, one quotient bit per cycle, truncating toward zero
	logic [63:0] rem_q, quo_q;
	logic [63:0] den_q;
	logic neg_q, busy_q;
	logic [6:0] cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q[62:0], quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp <= '0;
			cnt_q <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
				rem_q <= '0;
				quo_q <= req.num[63] ? 64'(-req.num) : 64'(req.num);
				den_q <= {32'd0, req.den};
				neg_q <= req.num[63];
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					rsp.done <= 1'b1;
					rsp.quo <= neg_q ? -$signed(!trial[64] ? {quo_q[62:0], 1'b1}
						: {quo_q[62:0], 1'b0})
						: $signed(!trial[64] ? {quo_q[62:0], 1'b1} : {quo_q[62:0], 1'b0});
				end
			end
		end
	end
endmodule

### src/ddwo_cordic.sv
`timescale 1ns / 1ps
module ddwo_cordic (
	input logic clk,
	input logic arst_n,
	input ddwo_pkg::cordic_req_t req,
	output ddwo_pkg::cordic_rsp_t rsp
);
	import ddwo_pkg::*;

	typedef enum logic [2:0] {C_IDLE, C_MOD, C_FIX, C_RED1, C_RED2, C_ITER} cst_t;
	cst_t st_q;
	logic signed [33:0] x_q, y_q;
	logic signed [47:0] z_q;
	logic signed [31:0] a_q;
	logic neg_q;
	logic [StepW-1:0] i_q;
	logic signed [33:0] xs, ys, at;
	logic [32:0] mag_q;
	logic an_q;
	logic [3:0] k_q;
	logic [32:0] md_w;
	logic signed [32:0] ang_w;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = atan_q30(i_q);
	// 2pi scaled by the current power of two for the serial remainder
	assign md_w = 33'(QTwoPi) << k_q;
	assign ang_w = {req.angle[31], req.angle};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			rsp <= '0;
		end else begin
			rsp.done <= 1'b0;
			case (st_q)
				C_IDLE: if (req.start) begin
					// reduce the magnitude, restore the sign afterwards
					an_q <= ang_w[32];
					mag_q <= ang_w[32] ? 33'd0 - ang_w : ang_w;
					k_q <= 4'd13;
					st_q <= C_MOD;
				end
				C_MOD: begin
					// subtract at most one multiple of 2pi per cycle, largest first
					if (mag_q >= md_w) mag_q <= mag_q - md_w;
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) st_q <= C_FIX;
				end
				C_FIX: begin
					a_q <= an_q ? -$signed(mag_q[31:0]) : $signed(mag_q[31:0]);
					st_q <= C_RED1;
				end
				C_RED1: begin
					if (a_q > QPi) a_q <= a_q - QTwoPi;
					else if (a_q < -QPi) a_q <= a_q + QTwoPi;
					st_q <= C_RED2;
				end
				C_RED2: begin
					neg_q <= (a_q > QHalfPi) || (a_q < -QHalfPi);
					if (a_q > QHalfPi) z_q <= 48'(a_q - QPi) <<< 14;
					else if (a_q < -QHalfPi) z_q <= 48'(a_q + QPi) <<< 14;
					else z_q <= 48'(a_q) <<< 14;
					x_q <= CordicGain;
					y_q <= '0;
					i_q <= '0;
					st_q <= C_ITER;
				end
				C_ITER: begin
					if (!z_q[47]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 48'(at);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 48'(at);
					end
					i_q <= i_q + 1'b1;
					if (i_q == StepW'(CordicSteps - 1)) begin
						st_q <= C_IDLE;
						rsp.done <= 1'b1;
						rsp.cos_q <= neg_q ? -(!z_q[47] ? x_q - ys : x_q + ys)
							: (!z_q[47] ? x_q - ys : x_q + ys);
						rsp.sin_q <= neg_q ? -(!z_q[47] ? y_q + xs : y_q - xs)
							: (!z_q[47] ? y_q + xs : y_q - xs);
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule

### src/diff_drive_wheel_odometry_top.sv
`timescale 1ns / 1ps
// Each item runs through up to three passes of the serial divider and two
// CORDIC runs (14 range reduction steps, 16 rotations). The heading pass is
// skipped with zero separation, the two velocity passes when dt is zero.
// Throughput: one item at a time; next item taken once the result is taken.
// Reset: arst_n asynchronous, clears pose and previous sample, and sets the
// registers (radius 2163, separation 11141).
module diff_drive_wheel_odometry_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [17:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// left_angle[31:0], right_angle[63:32], stamp_us[95:64]
	input logic [95:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// pos_x, pos_y, heading, quat_z, quat_w, linear_velocity,
	// angular_velocity, velocity_valid, 7 zero bits
	output logic [199:0] m_tdata
);
	import ddwo_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DTH, S_DTHW, S_CS1, S_CS1W, S_MUL, S_LIN, S_LINW,
		S_ANG, S_ANGW, S_CS2, S_CS2W, S_OUT
	} st_t;
	st_t st_q;

	logic [15:0] radius_q;
	logic [17:0] sep_q;
	logic signed [31:0] last_l_q, last_r_q, pos_x_q, pos_y_q, head_q;
	logic [31:0] last_t_q, dt_q;
	logic signed [32:0] dl_q, dr_q;
	logic signed [31:0] ds_q, dth_q;
	logic signed [63:0] dthw_q;
	logic signed [31:0] lin_q, ang_q;
	logic signed [15:0] qz_q, qw_q;
	logic signed [33:0] c_q, s_q;
	logic valid_q;

	div_req_t dreq;
	div_rsp_t drsp;
	cordic_req_t creq;
	cordic_rsp_t crsp;

	ddwo_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));
	ddwo_cordic u_cordic (.clk, .arst_n, .req(creq), .rsp(crsp));

	logic signed [33:0] sum_w;
	logic signed [50:0] dsp_w;
	logic signed [67:0] mx_w, my_w;
	logic signed [65:0] nh_w;

	assign sum_w = dl_q + dr_q;
	assign dsp_w = sum_w * $signed({1'b0, radius_q});
	assign mx_w = ds_q * c_q;
	assign my_w = ds_q * s_q;
	assign nh_w = 66'(head_q) + 66'(dthw_q);

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = (st_q == S_OUT);
	assign m_tdata = {7'd0, valid_q, ang_q, lin_q, qw_q, qz_q, head_q, pos_y_q, pos_x_q};

	function automatic logic signed [15:0] clamp14(input logic signed [33:0] v);
		logic signed [17:0] t;
		begin
			t = v[33:16];
			if (t > 18'sd16384) return 16'sd16384;
			if (t < -18'sd16384) return -16'sd16384;
			return t[15:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			radius_q <= RadiusReset;
			sep_q <= SepReset;
			last_l_q <= '0;
			last_r_q <= '0;
			last_t_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q <= '0;
			dreq <= '0;
			creq <= '0;
		end else begin
			dreq.start <= 1'b0;
			creq.start <= 1'b0;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_RADIUS: radius_q <= cfg_data[15:0];
					REG_SEP: sep_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (s_tvalid) begin
					// take item: deltas against previous sample
					dl_q <= 33'($signed(s_tdata[31:0])) - 33'(last_l_q);
					dr_q <= 33'($signed(s_tdata[63:32])) - 33'(last_r_q);
					dt_q <= s_tdata[95:64] - last_t_q;
					last_l_q <= s_tdata[31:0];
					last_r_q <= s_tdata[63:32];
					last_t_q <= s_tdata[95:64];
					st_q <= S_DTH;
				end
				S_DTH: begin
					ds_q <= sat32(66'(dsp_w >>> 17));
					if (sep_q != '0) begin
						dreq.start <= 1'b1;
						dreq.num <= 64'((dr_q - dl_q) * $signed({1'b0, radius_q}));
						dreq.den <= {14'd0, sep_q};
						st_q <= S_DTHW;
					end else begin
						dthw_q <= '0;
						st_q <= S_CS1;
					end
				end
				S_DTHW: if (drsp.done) begin
					dthw_q <= drsp.quo;
					st_q <= S_CS1;
				end
				S_CS1: begin
					head_q <= sat32(nh_w);
					dth_q <= sat32(66'(dthw_q));
					creq.start <= 1'b1;
					creq.angle <= sat32(nh_w);
					st_q <= S_CS1W;
				end
				S_CS1W: if (crsp.done) begin
					c_q <= crsp.cos_q;
					s_q <= crsp.sin_q;
					st_q <= S_MUL;
				end
				S_MUL: begin
					pos_x_q <= sat32(66'(pos_x_q) + 66'(mx_w >>> 30));
					pos_y_q <= sat32(66'(pos_y_q) + 66'(my_w >>> 30));
					valid_q <= (dt_q != '0);
					lin_q <= '0;
					ang_q <= '0;
					st_q <= (dt_q != '0) ? S_LIN : S_CS2;
				end
				S_LIN: begin
					dreq.start <= 1'b1;
					dreq.num <= 64'(ds_q * $signed({1'b0, UsPerS}));
					dreq.den <= dt_q;
					st_q <= S_LINW;
				end
				S_LINW: if (drsp.done) begin
					lin_q <= sat32(66'(drsp.quo));
					st_q <= S_ANG;
				end
				S_ANG: begin
					dreq.start <= 1'b1;
					dreq.num <= 64'(dth_q * $signed({1'b0, UsPerS}));
					dreq.den <= dt_q;
					st_q <= S_ANGW;
				end
				S_ANGW: if (drsp.done) begin
					ang_q <= sat32(66'(drsp.quo));
					st_q <= S_CS2;
				end
				S_CS2: begin
					creq.start <= 1'b1;
					creq.angle <= head_q >>> 1;
					st_q <= S_CS2W;
				end
				S_CS2W: if (crsp.done) begin
					qz_q <= clamp14(crsp.sin_q);
					qw_q <= clamp14(crsp.cos_q);
					st_q <= S_OUT;
				end
				S_OUT: if (m_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/ddwo_checker.sv
`timescale 1ns / 1ps
module ddwo_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [199:0] m_tdata
);
	import ddwo_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input open while result pending");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken at once");
	a_quat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[111:96]) <= 16'sd16384)
			&& ($signed(m_tdata[111:96]) >= -16'sd16384))
		else $error("quat_z out of range");
endmodule

bind diff_drive_wheel_odometry_top ddwo_checker u_chk (.clk, .arst_n, .s_tvalid, .s_tready,
	.m_tvalid, .m_tready, .m_tdata);
